// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the calendar date info RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define CDI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that, when true, forces a consequence on the next clock edge.
`define CDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cdi_pkg.sv -----
// Package for the calendar date info core: widths, constants, calendar tables
// and the stage payload types. Depends on nothing.
package cdi_pkg;

    localparam int YearW  = 14;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int WdayW  = 3;
    localparam int DoyW   = 9;
    localparam int SumW   = 15;
    localparam int QuoW   = 8;

    // Reciprocal of 100 scaled by 2^19; exact for every operand below 43690.
    localparam int Recip100   = 5243;
    localparam int RecipShift = 19;

    localparam logic [MonthW-1:0] MonJan = 4'd1;
    localparam logic [MonthW-1:0] MonFeb = 4'd2;
    localparam logic [MonthW-1:0] MonDec = 4'd12;

    localparam logic [WdayW-1:0] WdThu = 3'd4;
    localparam logic [WdayW-1:0] WdFri = 3'd5;
    localparam logic [WdayW-1:0] WdSat = 3'd6;

    // Stage 1 payload: shifted year, quotients by 100 and the month offset term.
    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [YearW:0]    yy;
        logic [QuoW-1:0]   qy;
        logic [QuoW-1:0]   qyy;
        logic [4:0]        t31;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_s1;

    // Stage 2 payload: leap flag and the weekday sum.
    typedef struct packed {
        logic              leap;
        logic [SumW-1:0]   sum;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_s2;

    // Final result fields.
    typedef struct packed {
        logic             valid_res;
        logic [WdayW-1:0] weekday;
        logic             weekend_flag;
        logic             week_end_flag;
        logic [WdayW-1:0] days_to_week_end;
        logic [DayW-1:0]  days_to_month_end;
        logic [DoyW-1:0]  days_to_year_end;
    } t_result;

    // Month length in a common year; zero for codes that are not months.
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon);
        logic [DayW-1:0] len;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before this one, common year.
    function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] mon);
        logic [DoyW-1:0] cnt;
        case (mon)
            4'd2:    cnt = 9'd31;
            4'd3:    cnt = 9'd59;
            4'd4:    cnt = 9'd90;
            4'd5:    cnt = 9'd120;
            4'd6:    cnt = 9'd151;
            4'd7:    cnt = 9'd181;
            4'd8:    cnt = 9'd212;
            4'd9:    cnt = 9'd243;
            4'd10:   cnt = 9'd273;
            4'd11:   cnt = 9'd304;
            4'd12:   cnt = 9'd334;
            default: cnt = 9'd0;
        endcase
        return cnt;
    endfunction

    // Floor of 31 * m / 12 for the March-based month index m.
    function automatic logic [4:0] month_term(input logic [MonthW-1:0] m);
        logic [4:0] t;
        case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/cdi_mod7.sv -----
// Remainder of the weekday sum by seven, using octal digit folding (8 = 1 mod 7).
// Depends on cdi_pkg for widths.
module cdi_mod7 (
    input  logic [cdi_pkg::SumW-1:0]  i_sum,
    output logic [cdi_pkg::WdayW-1:0] o_rem
);

    logic [5:0] fold1;
    logic [3:0] fold2;

    // First fold: five octal digits sum to at most 35.
    assign fold1 = 6'(i_sum[2:0]) + 6'(i_sum[5:3]) + 6'(i_sum[8:6])
                 + 6'(i_sum[11:9]) + 6'(i_sum[14:12]);

    // Second fold: two octal digits of a value up to 35 sum to at most 10.
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);

    // Final correction into 0..6.
    always_comb begin
        if (fold2 >= 4'd7) begin
            o_rem = 3'(fold2 - 4'd7);
        end else begin
            o_rem = fold2[2:0];
        end
    end

endmodule

// ----- hw/rtl/calendar_date_info_core.sv -----
// Calendar date info core: weekday, week flags and days left in month and year.
// Depends on cdi_pkg, cdi_mod7 and assert_macros.svh.
// Takes one request per cycle unless i_ready stalls; o_valid is stage 3's valid bit.
// Each of the three register stages moves on when it is empty or the next one
// takes its contents, so a stall on i_ready holds every stage without loss.
// Reset (synchronous, active low) clears the stage valid bits only.
`include "assert_macros.svh"

module calendar_date_info_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cdi_pkg::YearW-1:0]   i_year,
    input  logic [cdi_pkg::MonthW-1:0]  i_month,
    input  logic [cdi_pkg::DayW-1:0]    i_day,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_valid_res,
    output logic [cdi_pkg::WdayW-1:0]   o_weekday,
    output logic                        o_weekend_flag,
    output logic                        o_week_end_flag,
    output logic [cdi_pkg::WdayW-1:0]   o_days_to_week_end,
    output logic [cdi_pkg::DayW-1:0]    o_days_to_month_end,
    output logic [cdi_pkg::DoyW-1:0]    o_days_to_year_end
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    cdi_pkg::t_s1     r_s1, n_s1;
    cdi_pkg::t_s2     r_s2, n_s2;
    cdi_pkg::t_result r_out, n_out;

    // Stage handshake: a stage advances when empty or when its successor advances.
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1: March-based year and month, and quotients by 100 via reciprocal.
    logic                        s1_jan_feb;
    logic [cdi_pkg::MonthW-1:0]  s1_m;
    logic [26:0]                 s1_py;
    logic [27:0]                 s1_pyy;

    always_comb begin
        s1_jan_feb  = (i_month == cdi_pkg::MonJan) || (i_month == cdi_pkg::MonFeb);
        s1_m        = s1_jan_feb ? (i_month + 4'd10) : (i_month - 4'd2);
        n_s1.year   = i_year;
        n_s1.yy     = 15'(i_year) + 15'd400 - 15'(s1_jan_feb);
        s1_py       = 27'(i_year) * 27'(cdi_pkg::Recip100);
        s1_pyy      = 28'(n_s1.yy) * 28'(cdi_pkg::Recip100);
        n_s1.qy     = s1_py[cdi_pkg::RecipShift +: cdi_pkg::QuoW];
        n_s1.qyy    = s1_pyy[cdi_pkg::RecipShift +: cdi_pkg::QuoW];
        n_s1.t31    = cdi_pkg::month_term(s1_m);
        n_s1.month  = i_month;
        n_s1.day    = i_day;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= n_s1;
    end

    // Stage 2: leap-year test from the year remainder, and the weekday sum.
    logic [cdi_pkg::YearW-1:0] s2_diff;
    logic [6:0]                s2_rem100;
    logic [15:0]               s2_sum;

    always_comb begin
        s2_diff    = r_s1.year - 14'(14'(r_s1.qy) * 14'd100);
        s2_rem100  = s2_diff[6:0];
        n_s2.leap  = ((r_s1.year[1:0] == 2'd0) && (s2_rem100 != 7'd0))
                   || ((s2_rem100 == 7'd0) && (r_s1.qy[1:0] == 2'd0));
        s2_sum     = 16'(r_s1.day) + 16'(r_s1.yy) + 16'(r_s1.yy >> 2)
                   - 16'(r_s1.qyy) + 16'(r_s1.qyy >> 2) + 16'(r_s1.t31);
        n_s2.sum   = s2_sum[cdi_pkg::SumW-1:0];
        n_s2.month = r_s1.month;
        n_s2.day   = r_s1.day;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) r_s2 <= n_s2;
    end

    // Stage 3: weekday, validity and the remaining-day counts.
    logic [cdi_pkg::WdayW-1:0] s3_wd;
    logic [cdi_pkg::DayW-1:0]  s3_mlen;
    logic [cdi_pkg::DoyW-1:0]  s3_doy;
    logic [cdi_pkg::DoyW-1:0]  s3_ylen;
    logic                      s3_mon_ok;
    logic                      s3_ok;

    cdi_mod7 u_mod7 (
        .i_sum (r_s2.sum),
        .o_rem (s3_wd)
    );

    always_comb begin
        s3_mon_ok = (r_s2.month >= cdi_pkg::MonJan) && (r_s2.month <= cdi_pkg::MonDec);
        if ((r_s2.month == cdi_pkg::MonFeb) && r_s2.leap) begin
            s3_mlen = 5'd29;
        end else begin
            s3_mlen = cdi_pkg::month_len(r_s2.month);
        end
        s3_ok   = s3_mon_ok && (r_s2.day != 5'd0) && (r_s2.day <= s3_mlen);
        s3_doy  = cdi_pkg::days_before(r_s2.month) + 9'(r_s2.day)
                + 9'(r_s2.leap && (r_s2.month > cdi_pkg::MonFeb));
        s3_ylen = r_s2.leap ? 9'd366 : 9'd365;

        n_out = '0;
        if (s3_ok) begin
            n_out.valid_res         = 1'b1;
            n_out.weekday           = s3_wd;
            n_out.weekend_flag      = (s3_wd == cdi_pkg::WdThu) || (s3_wd == cdi_pkg::WdFri);
            n_out.week_end_flag     = (s3_wd == cdi_pkg::WdFri);
            n_out.days_to_week_end  = cdi_pkg::WdSat - s3_wd;
            n_out.days_to_month_end = s3_mlen - r_s2.day + 5'd1;
            n_out.days_to_year_end  = s3_ylen - s3_doy + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) r_out <= n_out;
    end

    // Output ports.
    assign o_valid             = r_v3;
    assign o_valid_res         = r_out.valid_res;
    assign o_weekday           = r_out.weekday;
    assign o_weekend_flag      = r_out.weekend_flag;
    assign o_week_end_flag     = r_out.week_end_flag;
    assign o_days_to_week_end  = r_out.days_to_week_end;
    assign o_days_to_month_end = r_out.days_to_month_end;
    assign o_days_to_year_end  = r_out.days_to_year_end;

    // Conditions on the result fields used by the checks below.
    logic chk_zero;
    logic chk_counts;
    logic chk_week;

    assign chk_zero   = (o_weekday == 3'd0) && (o_days_to_week_end == 3'd0)
                      && (o_days_to_month_end == 5'd0) && (o_days_to_year_end == 9'd0)
                      && !o_weekend_flag && !o_week_end_flag;
    assign chk_counts = (o_weekday <= cdi_pkg::WdSat) && (o_days_to_month_end != 5'd0)
                      && (o_days_to_year_end != 9'd0);
    assign chk_week   = (3'(o_weekday + o_days_to_week_end) == cdi_pkg::WdSat)
                      && (o_week_end_flag == (o_weekday == cdi_pkg::WdFri));

    // Checks on the result encoding and on stall behavior inside the pipeline.
    `CDI_ASSERT(a_invalid_zero, (o_valid && !o_valid_res) |-> chk_zero, "invalid date, fields set")
    `CDI_ASSERT(a_valid_counts, (o_valid && o_valid_res) |-> chk_counts, "bad weekday or counts")
    `CDI_ASSERT(a_week_consistent, (o_valid && o_valid_res) |-> chk_week, "week fields disagree")
    `CDI_ASSERT_NEXT(a_mid_stall_hold, !rdy2, r_v2 && $stable(r_s2), "stage 2 lost its item")

endmodule

// ----- tb/calendar_date_info_core_test.sv -----
// Self-checking testbench for calendar_date_info_core: dates go in over a valid/ready
// request channel and calendar facts come back, checked against an in-bench predictor.
// Depends on cdi_pkg and the calendar_date_info_core RTL.
`timescale 1ns / 100ps

module calendar_date_info_core_test;

    // Keeps predicted calendar facts in request order and checks each result.
    class calendar_scoreboard;
        cdi_pkg::t_result facts_q[$];
        int unsigned      requests;
        int unsigned      invalid_dates;
        int unsigned      results_checked;
        int unsigned      errors;

        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Long months alternate, with the run of two long months at July and August.
        static function int unsigned month_days(int unsigned mo, bit leap);
            if (mo == 2)
                return leap ? 29 : 28;
            return 30 + ((mo ^ (mo >> 3)) & 1);
        endfunction

        // Weekday by the March-based count, shifted 400 years so nothing goes negative.
        function cdi_pkg::t_result date_facts(int unsigned y, int unsigned mo, int unsigned d);
            cdi_pkg::t_result r;
            bit               leap;
            int unsigned      mlen, a, yy, mi, s, wd, doy, k;
            r    = '0;
            leap = leap_year(y);
            if (mo < 1 || mo > 12)
                return r;
            mlen = month_days(mo, leap);
            if (d < 1 || d > mlen)
                return r;
            a   = (mo <= 2) ? 1 : 0;
            yy  = y + 400 - a;
            mi  = mo + 12 * a - 2;
            s   = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mi) / 12;
            wd  = s % 7;
            doy = d;
            for (k = 1; k < mo; k++)
                doy += month_days(k, leap);
            r.valid_res         = 1'b1;
            r.weekday           = wd[cdi_pkg::WdayW-1:0];
            r.weekend_flag      = (wd == 4 || wd == 5);
            r.week_end_flag     = (wd == 5);
            r.days_to_week_end  = 3'(6 - wd);
            r.days_to_month_end = 5'(mlen - d + 1);
            r.days_to_year_end  = 9'((leap ? 366 : 365) - doy + 1);
            return r;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("ERROR: %s", msg);
        endtask

        function int pending();
            return facts_q.size();
        endfunction

        task note_request(int unsigned y, int unsigned mo, int unsigned d);
            cdi_pkg::t_result r;
            r = date_facts(y, mo, d);
            requests++;
            if (!r.valid_res)
                invalid_dates++;
            facts_q.push_back(r);
        endtask

        task cmp(string fld, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d: %s is %0d, expected %0d",
                                 results_checked, fld, got, want));
        endtask

        task check_result(cdi_pkg::t_result got);
            cdi_pkg::t_result want;
            if (facts_q.size() == 0) begin
                report($sformatf("result with no request outstanding (after %0d results)",
                                 results_checked));
                return;
            end
            want = facts_q.pop_front();
            cmp("valid_res", got.valid_res, want.valid_res);
            cmp("weekday", got.weekday, want.weekday);
            cmp("weekend_flag", got.weekend_flag, want.weekend_flag);
            cmp("week_end_flag", got.week_end_flag, want.week_end_flag);
            cmp("days_to_week_end", got.days_to_week_end, want.days_to_week_end);
            cmp("days_to_month_end", got.days_to_month_end, want.days_to_month_end);
            cmp("days_to_year_end", got.days_to_year_end, want.days_to_year_end);
            results_checked++;
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [cdi_pkg::YearW-1:0]    i_year;
    logic [cdi_pkg::MonthW-1:0]   i_month;
    logic [cdi_pkg::DayW-1:0]     i_day;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_valid_res;
    logic [cdi_pkg::WdayW-1:0]    o_weekday;
    logic                         o_weekend_flag;
    logic                         o_week_end_flag;
    logic [cdi_pkg::WdayW-1:0]    o_days_to_week_end;
    logic [cdi_pkg::DayW-1:0]     o_days_to_month_end;
    logic [cdi_pkg::DoyW-1:0]     o_days_to_year_end;

    calendar_scoreboard sb;
    bit                 hold_request;
    int unsigned        dates_sent;

    calendar_date_info_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_year              (i_year),
        .i_month             (i_month),
        .i_day               (i_day),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_valid_res         (o_valid_res),
        .o_weekday           (o_weekday),
        .o_weekend_flag      (o_weekend_flag),
        .o_week_end_flag     (o_week_end_flag),
        .o_days_to_week_end  (o_days_to_week_end),
        .o_days_to_month_end (o_days_to_month_end),
        .o_days_to_year_end  (o_days_to_year_end)
    );

    // Free-running 20 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a run that hangs is a failure.
    initial begin
        #(64'd5_000_000);
        $display("Verification failed");
        $finish;
    end

    // Both channels are sampled at the rising edge; inputs only move on the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_request(i_year, i_month, i_day);
            if (o_valid && i_ready)
                sb.check_result('{o_valid_res, o_weekday, o_weekend_flag, o_week_end_flag,
                                  o_days_to_week_end, o_days_to_month_end,
                                  o_days_to_year_end});
        end
    end

    // Receiver: switches among stall styles, and honors a request for one long hold-off.
    initial begin
        int unsigned hold_left;
        int unsigned stretch;
        int unsigned style;
        int unsigned phase;
        logic [7:0]  pattern;
        hold_left = 0;
        stretch   = 0;
        style     = 0;
        phase     = 0;
        pattern   = 8'hff;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                stretch = $urandom_range(20, 80);
                style   = $urandom_range(0, 3);
                pattern = 8'($urandom);
            end
            stretch--;
            phase++;
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 59;
                i_ready      = 1'b0;
            end else begin
                case (style)
                    0:       i_ready = 1'b1;
                    1:       i_ready = pattern[phase % 8];
                    2:       i_ready = ($urandom_range(0, 3) != 0);
                    default: i_ready = 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Offers one date and holds it until the block takes it.
    task send_date(int unsigned y, int unsigned mo, int unsigned d);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_year  = y[cdi_pkg::YearW-1:0];
        i_month = mo[cdi_pkg::MonthW-1:0];
        i_day   = d[cdi_pkg::DayW-1:0];
        do
            @(posedge i_clk);
        while (!o_ready);
        dates_sent++;
    endtask

    task idle_for(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task wait_drained();
        idle_for(1);
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed dates with month ends, February and century years weighted up,
    // the rest noise across the full field ranges and days just past the month.
    task random_date(output int unsigned y, output int unsigned mo, output int unsigned d);
        int unsigned pick;
        int unsigned mlen;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            y = $urandom_range(1, 9999);
        else if (pick < 80)
            y = $urandom_range(0, 99) * 100;
        else
            y = $urandom_range(0, (1 << cdi_pkg::YearW) - 1);
        mo   = ($urandom_range(0, 4) == 0) ? cdi_pkg::MonFeb
                                           : $urandom_range(cdi_pkg::MonJan, cdi_pkg::MonDec);
        mlen = calendar_scoreboard::month_days(mo, calendar_scoreboard::leap_year(y));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            d = mlen;
        else if (pick < 30)
            d = 1;
        else if (pick < 85)
            d = $urandom_range(1, mlen);
        else if (pick < 92) begin
            mo = $urandom_range(0, 15);
            d  = $urandom_range(0, 31);
        end else if (pick < 97)
            d = (mlen == 31) ? 0 : $urandom_range(mlen + 1, 31);
        else
            d = 0;
    endtask

    // Main sequence: reset, directed dates, a forced back-up, then random bursts.
    initial begin
        int unsigned y, mo, d;
        int unsigned burst;
        int unsigned i;
        sb           = new();
        hold_request = 1'b0;
        dates_sent   = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_year       = '0;
        i_month      = '0;
        i_day        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: range edges, leap rules, every weekday flag, invalid months and days.
        send_date(1, 1, 1);
        send_date(9999, 12, 31);
        send_date(2000, 2, 29);
        send_date(1900, 2, 29);
        send_date(1900, 2, 28);
        send_date(2024, 2, 29);
        send_date(2023, 2, 29);
        send_date(2023, 1, 1);
        send_date(2024, 1, 4);
        send_date(2024, 1, 5);
        send_date(2024, 1, 6);
        send_date(2024, 3, 1);
        send_date(2024, 12, 31);
        send_date(2023, 4, 31);
        send_date(2023, 6, 30);
        send_date(2023, 0, 15);
        send_date(2023, 13, 1);
        send_date(2023, 15, 31);
        send_date(2023, 7, 0);
        send_date(0, 2, 29);
        send_date(0, 1, 1);
        send_date(16383, 12, 31);
        send_date(10000, 3, 1);
        send_date(11'h555 << 3 | 2, 8, 31);
        send_date(14'h2aaa, 10, 21);
        wait_drained();

        // Receiver holds off for a long stretch while dates keep coming.
        hold_request = 1'b1;
        repeat (30) begin
            random_date(y, mo, d);
            send_date(y, mo, d);
        end
        wait_drained();

        // Random bursts, with a full drain now and then.
        i = 0;
        while (dates_sent < 750) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 16);
            repeat (burst) begin
                random_date(y, mo, d);
                send_date(y, mo, d);
            end
            if ($urandom_range(0, 2) != 0)
                idle_for($urandom_range(1, 8));
            i++;
            if (i % 15 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d dates (%0d not real dates); %0d results checked field by field.",
                 sb.requests, sb.invalid_dates, sb.results_checked);
        $display("Mismatches found: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
